>>> hw/rtl/point_matrix_projective_transform_macros.svh
// Assertion macros shared by the point transform RTL.
// Every macro expects aclk and aresetn in the scope where it is used.
`ifndef POINT_MATRIX_PROJECTIVE_TRANSFORM_MACROS_SVH
`define POINT_MATRIX_PROJECTIVE_TRANSFORM_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define PMPT_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("pmpt check failed");
// Antecedent in one cycle implies consequent in the next.
`define PMPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pmpt check failed");
`else
`define PMPT_ASSERT(lbl, cond)
`define PMPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/pmpt_pkg.sv
// Widths, types, register codes and helper functions of the point transform.
// No dependencies; used by every module of the block.
package pmpt_pkg;

    localparam int POINT_WIDTH = 32;
    localparam int COEF_WIDTH  = 16;
    localparam int POINT_FRAC  = 16;
    localparam int COEF_FRAC   = 12;
    localparam int LANE_W      = 16;
    localparam int ROW_W       = 4 * LANE_W;
    localparam int CFG_IDX_W   = 8;

    localparam int PROD_W = POINT_WIDTH + COEF_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int NUM_W  = SUM_W + POINT_FRAC + 1;
    localparam int HI_W   = NUM_W - POINT_WIDTH;
    localparam int REM_W  = SUM_W + 1;
    localparam int CMP_W  = (HI_W > REM_W) ? HI_W : REM_W;

    localparam int MAC_LAT  = 2;
    localparam int DIV_LAT  = POINT_WIDTH + 3;
    localparam int PIPE_LAT = MAC_LAT + DIV_LAT;

    typedef logic signed [POINT_WIDTH-1:0] point_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [SUM_W-1:0]              mag_t;
    typedef logic [NUM_W-1:0]              num_t;
    typedef logic [REM_W-1:0]              rem_t;
    typedef logic [POINT_WIDTH-1:0]        quo_t;
    typedef logic [ROW_W-1:0]              row_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0,
        REG_ROW1,
        REG_ROW2,
        REG_ROW3
    } reg_idx_t;

    // 1.0 in Q4.12
    localparam logic [LANE_W-1:0] COEF_ONE = LANE_W'(1 << COEF_FRAC);
    localparam row_t ROW0_RESET = ROW_W'(COEF_ONE);
    localparam row_t ROW1_RESET = ROW_W'(COEF_ONE) << LANE_W;
    localparam row_t ROW2_RESET = ROW_W'(COEF_ONE) << (2 * LANE_W);
    localparam row_t ROW3_RESET = ROW_W'(COEF_ONE) << (3 * LANE_W);

    localparam quo_t Q_LIM = quo_t'(1) << (POINT_WIDTH - 1);
    localparam quo_t Q_MAX = Q_LIM - quo_t'(1);

    typedef struct packed {
        point_t val;
        logic   sat;
    } coord_t;

    typedef struct packed {
        point_t x;
        point_t y;
        point_t z;
        logic   w_zero;
        logic   saturated;
    } res_t;

    function automatic coef_t coef_of(row_t row, int col);
        return coef_t'(row[LANE_W*col +: COEF_WIDTH]);
    endfunction

    // Apply sign and clamp to a rounded quotient magnitude.
    function automatic coord_t finish_coord(quo_t q, logic ovf, logic neg);
        coord_t r;
        logic   over;
        over = ovf || (neg ? (q > Q_LIM) : (q > Q_MAX));
        r.sat = over;
        if (over) begin
            r.val = neg ? point_t'(Q_LIM) : point_t'(Q_MAX);
        end else begin
            r.val = neg ? point_t'(~q + quo_t'(1)) : point_t'(q);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/point_matrix_projective_transform.sv
// Top level of the 4x4 projective point transform: matrix registers, valid
// pipeline, three divide lanes and output buffer. Uses pmpt_pkg and all pmpt_* modules.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  s_       | s_valid s_ready s_point_x/y/z             | in
//  m_       | m_valid m_ready m_out_x/y/z w_zero sat    | out
//  cfg_     | cfg_valid cfg_ready cfg_index cfg_data    | in
//
// One point per clock while s_ready is high. From accept to m_valid a point passes
// two multiply/sum stages, three prep stages and one quotient bit per stage
// in each divide lane, then the output register.
// Synchronous reset clears all valid bits and loads the identity matrix.
// A full skid entry holds the whole pipeline; s_ready is low exactly then.
`include "point_matrix_projective_transform_macros.svh"
module point_matrix_projective_transform
    import pmpt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  point_t               s_point_x,
    input  point_t               s_point_y,
    input  point_t               s_point_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output point_t               m_out_x,
    output point_t               m_out_y,
    output point_t               m_out_z,
    output logic                 m_w_zero,
    output logic                 m_saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  row_t                 cfg_data
);

    row_t                row_reg [4];
    logic [PIPE_LAT-1:0] vld_reg;
    logic [DIV_LAT-1:0]  wz_reg;
    sum_t                sum [4];
    quo_t                q [3];
    logic                ovf [3];
    logic                neg [3];
    coord_t              coord [3];
    res_t                push_data;
    res_t                m_data;
    logic                adv;
    logic                push;
    logic                full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= ROW0_RESET;
            row_reg[1] <= ROW1_RESET;
            row_reg[2] <= ROW2_RESET;
            row_reg[3] <= ROW3_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                REG_ROW3: row_reg[3] <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign adv     = !full;
    assign s_ready = adv;
    assign push    = adv & vld_reg[PIPE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    // zero w flag rides alongside the divide lanes
    always_ff @(posedge aclk) begin
        if (adv) begin
            wz_reg <= {wz_reg[DIV_LAT-2:0], (sum[3] == '0)};
        end
    end

    pmpt_mac u_mac (
        .aclk    (aclk),
        .en      (adv),
        .point_x (s_point_x),
        .point_y (s_point_y),
        .point_z (s_point_z),
        .row     (row_reg),
        .sum     (sum)
    );

    for (genvar c = 0; c < 3; c++) begin : g_lane
        pmpt_div u_div (
            .aclk    (aclk),
            .en      (adv),
            .num_in  (sum[c]),
            .w_in    (sum[3]),
            .q_out   (q[c]),
            .ovf_out (ovf[c]),
            .neg_out (neg[c])
        );

        always_comb coord[c] = finish_coord(q[c], ovf[c], neg[c]);
    end

    always_comb begin
        if (wz_reg[DIV_LAT-1]) begin
            push_data.x         = '0;
            push_data.y         = '0;
            push_data.z         = '0;
            push_data.w_zero    = 1'b1;
            push_data.saturated = 1'b0;
        end else begin
            push_data.x         = coord[0].val;
            push_data.y         = coord[1].val;
            push_data.z         = coord[2].val;
            push_data.w_zero    = 1'b0;
            push_data.saturated = coord[0].sat | coord[1].sat | coord[2].sat;
        end
    end

    pmpt_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_out_x     = m_data.x;
    assign m_out_y     = m_data.y;
    assign m_out_z     = m_data.z;
    assign m_w_zero    = m_data.w_zero;
    assign m_saturated = m_data.saturated;

    `PMPT_ASSERT(a_wzero_clean, !(m_valid && m_w_zero) || (m_out_x == '0 && m_out_y == '0 && m_out_z == '0 && !m_saturated))
    `PMPT_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld_reg))

endmodule

>>> hw/rtl/pmpt_div.sv
// One divide lane: magnitude prep, rounding numerator, overflow check and a
// restoring divider with one quotient bit per pipeline stage. Uses pmpt_pkg.
module pmpt_div
    import pmpt_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  sum_t num_in,
    input  sum_t w_in,
    output quo_t q_out,
    output logic ovf_out,
    output logic neg_out
);

    mag_t nmag_reg;
    mag_t wmag_reg;
    logic neg1_reg;
    num_t num_reg;
    rem_t den2_reg;
    logic neg2_reg;

    rem_t rem_reg [POINT_WIDTH];
    quo_t lo_reg  [POINT_WIDTH];
    rem_t den_reg [POINT_WIDTH];
    quo_t q_reg   [POINT_WIDTH+1];
    logic neg_reg [POINT_WIDTH+1];
    logic ovf_reg [POINT_WIDTH+1];

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_ext;

    always_comb begin
        hi_ext  = CMP_W'(num_reg[NUM_W-1:POINT_WIDTH]);
        den_ext = CMP_W'(den2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nmag_reg <= num_in[SUM_W-1] ? mag_t'(-num_in) : mag_t'(num_in);
            wmag_reg <= w_in[SUM_W-1] ? mag_t'(-w_in) : mag_t'(w_in);
            neg1_reg <= num_in[SUM_W-1] ^ w_in[SUM_W-1];

            // |N| * 2^(frac+1) + |W| over 2|W| rounds half away from zero
            num_reg  <= (num_t'(nmag_reg) << (POINT_FRAC + 1)) + num_t'(wmag_reg);
            den2_reg <= {wmag_reg, 1'b0};
            neg2_reg <= neg1_reg;

            // quotient needs more than POINT_WIDTH bits: clamp later
            ovf_reg[0] <= hi_ext >= den_ext;
            rem_reg[0] <= rem_t'(num_reg[NUM_W-1:POINT_WIDTH]);
            lo_reg[0]  <= num_reg[POINT_WIDTH-1:0];
            den_reg[0] <= den2_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg2_reg;
        end
    end

    for (genvar k = 0; k < POINT_WIDTH; k++) begin : g_step
        logic [REM_W:0]   trial;
        logic [REM_W+1:0] diff;
        logic             take;
        rem_t             rem_next;

        always_comb begin
            trial    = {rem_reg[k], lo_reg[k][POINT_WIDTH-1]};
            diff     = {1'b0, trial} - {2'b00, den_reg[k]};
            take     = !diff[REM_W+1];
            rem_next = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1]   <= {q_reg[k][POINT_WIDTH-2:0], take};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < POINT_WIDTH - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= rem_next;
                    lo_reg[k+1]  <= lo_reg[k] << 1;
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign q_out   = q_reg[POINT_WIDTH];
    assign ovf_out = ovf_reg[POINT_WIDTH];
    assign neg_out = neg_reg[POINT_WIDTH];

endmodule

>>> hw/rtl/pmpt_mac.sv
// Matrix multiply front end: twelve coefficient products in one stage,
// four column sums with the row 3 offset in the next. Uses pmpt_pkg.
module pmpt_mac
    import pmpt_pkg::*;
(
    input  logic   aclk,
    input  logic   en,
    input  point_t point_x,
    input  point_t point_y,
    input  point_t point_z,
    input  row_t   row [4],
    output sum_t   sum [4]
);

    point_t pt [3];
    prod_t  prod_reg [4][3];
    sum_t   off_reg [4];
    sum_t   sum_reg [4];

    always_comb begin
        pt[0] = point_x;
        pt[1] = point_y;
        pt[2] = point_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 3; r++) begin
                    prod_reg[c][r] <= prod_t'(coef_of(row[r], c)) * prod_t'(pt[r]);
                end
                off_reg[c] <= sum_t'(coef_of(row[3], c)) <<< POINT_FRAC;
                sum_reg[c] <= sum_t'(prod_reg[c][0]) + sum_t'(prod_reg[c][1])
                            + sum_t'(prod_reg[c][2]) + off_reg[c];
            end
        end
    end

    assign sum = sum_reg;

endmodule

>>> hw/rtl/pmpt_obuf.sv
// Output register with one skid entry; parts the pipeline from m_ready.
// Uses pmpt_pkg for the result word type.
`include "point_matrix_projective_transform_macros.svh"
module pmpt_obuf
    import pmpt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    logic main_vld_reg, main_vld_next;
    logic skid_vld_reg, skid_vld_next;
    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic pop;

    assign pop = main_vld_reg & m_ready;

    always_comb begin
        main_vld_next = main_vld_reg;
        skid_vld_next = skid_vld_reg;
        main_next     = main_reg;
        skid_next     = skid_reg;
        if (pop) begin
            if (skid_vld_reg) begin
                main_next     = skid_reg;
                skid_vld_next = 1'b0;
            end else begin
                main_vld_next = push;
                main_next     = push_data;
            end
        end else if (push) begin
            if (!main_vld_reg) begin
                main_vld_next = 1'b1;
                main_next     = push_data;
            end else begin
                // park the word; the pipeline holds from the next cycle
                skid_vld_next = 1'b1;
                skid_next     = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            main_vld_reg <= main_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full    = skid_vld_reg;
    assign m_valid = main_vld_reg;
    assign m_data  = main_reg;

    `PMPT_ASSERT(a_skid_behind_main, !skid_vld_reg || main_vld_reg)
    `PMPT_ASSERT(a_no_push_when_full, !(push && skid_vld_reg))

endmodule

>>> sim/tb_point_matrix_projective_transform.sv
// Self-checking bench for point_matrix_projective_transform: directed and random
// points under several matrices and random handshake gaps, checked word by word
// against a projective predictor kept in the bench. Depends on pmpt_pkg and the RTL.
`timescale 1ns / 100ps

module tb_point_matrix_projective_transform
    import pmpt_pkg::*;
();

    localparam int IDLE_PCT      = 18;
    localparam int ROW_COUNT     = 4;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_POINTS  = 161;
    localparam int HOLD_CYCLES   = 250;
    localparam int LIMIT_NS      = 2_000_000;

    localparam logic [LANE_W-1:0] LANE_MAX      = 16'h7FFF;
    localparam logic [LANE_W-1:0] LANE_MIN      = 16'h8000;
    localparam logic [LANE_W-1:0] LANE_NEG_ONE  = 16'hF000;
    localparam logic [LANE_W-1:0] LANE_ALL_ONES = 16'hFFFF;
    localparam logic [LANE_W-1:0] LANE_LSB      = 16'h0001;
    localparam logic [LANE_W-1:0] LANE_TWO      = 16'h0002;

    localparam point_t POINT_MAX = {1'b0, {(POINT_WIDTH-1){1'b1}}};
    localparam point_t POINT_MIN = {1'b1, {(POINT_WIDTH-1){1'b0}}};
    localparam point_t ONE_POINT = point_t'(1) <<< POINT_FRAC;

    localparam logic [127:0] NEG_LIMIT = 128'(1) << (POINT_WIDTH - 1);
    localparam logic [127:0] POS_LIMIT = NEG_LIMIT - 128'(1);

    typedef struct packed {
        point_t x;
        point_t y;
        point_t z;
    } xyz_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    point_t               s_point_x = '0;
    point_t               s_point_y = '0;
    point_t               s_point_z = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    point_t               m_out_x;
    point_t               m_out_y;
    point_t               m_out_z;
    logic                 m_w_zero;
    logic                 m_saturated;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    row_t                 cfg_data  = '0;

    xyz_t point_q [$];
    res_t projected_q [$];
    row_t matrix [ROW_COUNT] = '{ROW0_RESET, ROW1_RESET, ROW2_RESET, ROW3_RESET};
    int   points_queued = 0;
    int   points_taken  = 0;
    int   mismatches    = 0;
    logic s_taken       = 1'b0;
    logic hold_rx       = 1'b0;
    wire  steady_run    = (points_taken >= 1200) && (points_taken < 1500);

    point_matrix_projective_transform dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_point_z   (s_point_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_w_zero    (m_w_zero),
        .m_saturated (m_saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Row vector times matrix, then divide columns 0..2 by column 3 with
    // round half away from zero and clamp to the point range; a zero column 3 gives w_zero.
    function automatic res_t project_point(point_t px, point_t py, point_t pz);
        longint       sums [4];
        logic [127:0] wmag, nmag, quo;
        logic         wneg, nneg;
        point_t       coord [3];
        logic         clamp;
        res_t         r;
        clamp = 1'b0;
        for (int c = 0; c < 4; c++) begin
            sums[c] = longint'(coef_t'(matrix[3][LANE_W*c +: COEF_WIDTH])) * 65536
                    + longint'(coef_t'(matrix[0][LANE_W*c +: COEF_WIDTH])) * longint'(px)
                    + longint'(coef_t'(matrix[1][LANE_W*c +: COEF_WIDTH])) * longint'(py)
                    + longint'(coef_t'(matrix[2][LANE_W*c +: COEF_WIDTH])) * longint'(pz);
        end
        if (sums[3] == 0) begin
            r.x = '0;
            r.y = '0;
            r.z = '0;
            r.w_zero = 1'b1;
            r.saturated = 1'b0;
            return r;
        end
        wneg = sums[3] < 0;
        wmag = 128'(wneg ? -sums[3] : sums[3]);
        for (int c = 0; c < 3; c++) begin
            nneg = sums[c] < 0;
            nmag = 128'(nneg ? -sums[c] : sums[c]);
            quo = ((nmag << (POINT_FRAC + 1)) + wmag) / (wmag << 1);
            if ((nneg != wneg) && (quo != 0)) begin
                if (quo > NEG_LIMIT) begin
                    coord[c] = POINT_MIN;
                    clamp = 1'b1;
                end else begin
                    coord[c] = point_t'(0 - quo[POINT_WIDTH-1:0]);
                end
            end else if (quo > POS_LIMIT) begin
                coord[c] = POINT_MAX;
                clamp = 1'b1;
            end else begin
                coord[c] = point_t'(quo[POINT_WIDTH-1:0]);
            end
        end
        r.x = coord[0];
        r.y = coord[1];
        r.z = coord[2];
        r.w_zero = 1'b0;
        r.saturated = clamp;
        return r;
    endfunction

    function automatic row_t make_row(logic [LANE_W-1:0] l0, logic [LANE_W-1:0] l1,
                                      logic [LANE_W-1:0] l2, logic [LANE_W-1:0] l3);
        return {l3, l2, l1, l0};
    endfunction

    function automatic logic [LANE_W-1:0] rand_lane();
        coef_t v;
        v = coef_t'($urandom);
        case ($urandom_range(5))
            0: begin
                case ($urandom_range(3))
                    0: v = LANE_MAX;
                    1: v = LANE_MIN;
                    2: v = COEF_ONE;
                    default: v = '0;
                endcase
            end
            1, 2: ;
            default: v = v >>> $urandom_range(COEF_WIDTH - 1);
        endcase
        return v;
    endfunction

    function automatic row_t rand_row();
        return make_row(rand_lane(), rand_lane(), rand_lane(), rand_lane());
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p = point_t'($urandom);
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: p = POINT_MAX;
                    1: p = POINT_MIN;
                    2: p = ONE_POINT;
                    3: p = -1;
                    default: p = '0;
                endcase
            end
            1, 2, 3: ;
            default: p = p >>> $urandom_range(POINT_WIDTH - 1);
        endcase
        return p;
    endfunction

    task automatic flag_mismatch(input string what, input logic [POINT_WIDTH-1:0] got,
                                 input logic [POINT_WIDTH-1:0] want);
        $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_point(input point_t x, input point_t y, input point_t z);
        point_q.push_back('{x, y, z});
        points_queued++;
    endtask

    // Hold until every queued point is taken and every result has come back.
    task automatic wait_drained();
        do @(negedge aclk);
        while (points_taken != points_queued || projected_q.size() != 0);
    endtask

    task automatic write_row(input logic [CFG_IDX_W-1:0] idx, input row_t data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        if (idx < ROW_COUNT)
            matrix[idx[1:0]] = data;
    endtask

    task automatic load_matrix(input row_t r0, input row_t r1, input row_t r2,
                               input row_t r3, input bit stray);
        if (stray)
            write_row(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, ROW_COUNT)), rand_row());
        write_row(REG_ROW0, r0);
        write_row(REG_ROW1, r1);
        write_row(REG_ROW2, r2);
        write_row(REG_ROW3, r3);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sender: advance to the next word only once the current one is taken.
    always @(negedge aclk) begin
        xyz_t pt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (point_q.size() > 0 && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
                pt = point_q.pop_front();
                s_valid   <= 1'b1;
                s_point_x <= pt.x;
                s_point_y <= pt.y;
                s_point_z <= pt.z;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !hold_rx && (steady_run || $urandom_range(99) >= IDLE_PCT);
    end

    // Check the outgoing word first, then record the incoming one.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (projected_q.size() == 0) begin
                    flag_mismatch("unexpected word", m_out_x, '0);
                end else begin
                    want = projected_q.pop_front();
                    if (m_out_x !== want.x) flag_mismatch("out_x", m_out_x, want.x);
                    if (m_out_y !== want.y) flag_mismatch("out_y", m_out_y, want.y);
                    if (m_out_z !== want.z) flag_mismatch("out_z", m_out_z, want.z);
                    if (m_w_zero !== want.w_zero)
                        flag_mismatch("w_zero", POINT_WIDTH'(m_w_zero),
                                      POINT_WIDTH'(want.w_zero));
                    if (m_saturated !== want.saturated)
                        flag_mismatch("saturated", POINT_WIDTH'(m_saturated),
                                      POINT_WIDTH'(want.saturated));
                end
            end
            if (s_valid && s_ready) begin
                projected_q.push_back(project_point(s_point_x, s_point_y, s_point_z));
                points_taken++;
            end
        end
        s_taken <= aresetn && s_valid && s_ready;
    end

    // Back-pressure burst: stall the result side long enough to fill the pipe.
    initial begin
        wait (points_taken >= 700);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
    end

    initial begin
        #LIMIT_NS;
        $display("point_matrix_projective_transform regression: fail");
        $finish;
    end

    initial begin
        row_t r0, r1, r2, r3;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // identity matrix out of reset
        queue_point(0, 0, 0);
        queue_point(POINT_MAX, POINT_MAX, POINT_MAX);
        queue_point(POINT_MIN, POINT_MIN, POINT_MIN);
        queue_point(POINT_MAX, POINT_MIN, -1);
        queue_point(ONE_POINT, -ONE_POINT, 1);
        queue_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);

        // w column all zero
        wait_drained();
        load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET, '0, 1'b0);
        queue_point(ONE_POINT, POINT_MAX, POINT_MIN);
        queue_point(0, 0, 0);

        // w = x - 1.0, zero only at x = 1.0
        wait_drained();
        load_matrix(make_row(COEF_ONE, '0, '0, COEF_ONE), ROW1_RESET, ROW2_RESET,
                    make_row('0, '0, '0, LANE_NEG_ONE), 1'b1);
        queue_point(ONE_POINT, 5, 7);
        queue_point(ONE_POINT <<< 1, 5, 7);

        // tiny w drives the quotients out of range both ways
        wait_drained();
        load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET, make_row('0, '0, '0, LANE_LSB), 1'b0);
        queue_point(point_t'(1) <<< 20, -(point_t'(1) <<< 20), 3);
        queue_point(3, -3, 0);
        queue_point(POINT_MIN, 0, POINT_MAX);

        // negative w flips signs; the most negative input overflows
        wait_drained();
        load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET,
                    make_row('0, '0, '0, LANE_NEG_ONE), 1'b0);
        queue_point(POINT_MIN, POINT_MAX, 1);
        queue_point(-1, 0, ONE_POINT);

        // w = 2 * m, odd inputs land exactly on half
        wait_drained();
        load_matrix(make_row(LANE_LSB, '0, '0, '0), make_row('0, LANE_LSB, '0, '0),
                    make_row('0, '0, LANE_LSB, '0), make_row('0, '0, '0, LANE_TWO), 1'b0);
        queue_point(1, -1, 3);
        queue_point(-3, 5, -5);
        queue_point(POINT_MAX, POINT_MIN, 0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: r0 = {4{LANE_MAX}};
                1: r0 = {4{LANE_MIN}};
                2: r0 = {4{LANE_ALL_ONES}};
                default: r0 = rand_row();
            endcase
            if (ph < 3) begin
                r1 = r0;
                r2 = r0;
                r3 = r0;
            end else if (ph == 3) begin
                // perspective: w follows z alone
                r0 = make_row(rand_lane(), rand_lane(), rand_lane(), '0);
                r1 = make_row(rand_lane(), rand_lane(), rand_lane(), '0);
                r2 = make_row(rand_lane(), rand_lane(), rand_lane(), COEF_ONE);
                r3 = make_row(rand_lane(), rand_lane(), rand_lane(), '0);
            end else begin
                r1 = rand_row();
                r2 = rand_row();
                r3 = rand_row();
            end
            load_matrix(r0, r1, r2, r3, ph % 3 == 1);
            for (int i = 0; i < PHASE_POINTS; i++)
                queue_point(rand_point(), rand_point(), rand_point());
        end

        wait_drained();
        repeat (PIPE_LAT + 16) @(posedge aclk);
        if (mismatches == 0)
            $display("point_matrix_projective_transform regression: pass");
        else
            $display("point_matrix_projective_transform regression: fail");
        $finish;
    end

endmodule
